[hdl/ipq_pkg.sv]
// Package for the indexed priority queue: beat payload structs, op codes,
// status codes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package ipq_pkg;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic ST_OK    = 1'b0;
   localparam logic ST_EMPTY = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [6:0]  index;
      logic [31:0] key_value;
   } req_type;

   typedef struct packed {
      logic [6:0]  top_index;
      logic [31:0] top_key;
      logic [7:0]  count;
      logic        is_empty;
      logic        status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_P_MAP,
      S_P_MAPW,
      S_P_CMP,
      S_UP,
      S_UP_CMP,
      S_O_START,
      S_O_R1,
      S_O_RL,
      S_DN,
      S_DN_L,
      S_DN_R,
      S_DN_CMP,
      S_CLR,
      S_TOP,
      S_FIN
   } state_type;

endpackage

[hdl/indexed_priority_queue.sv]
// Indexed priority queue (binary heap with a per-id position map).
// Depends on ipq_pkg and ipq_ram.
//
// Usage: one request beat on req_* (push/improve, pop or clear) gives one
// response beat on rsp_* with the top entry, count, empty flag and status.
// csr_wr_en/csr_wr_data write the ordering bit (0 min heap, 1 max heap);
// write it only while the queue is idle.
// One request is worked on at a time; req_stall is high while busy.
// Heap slots and the position map sit in two RAMs with registered reads,
// so every sift level costs memory round trips.
// A clear sweeps the position map one entry a cycle.
// After reset the position map is swept to zero with req_stall high. The
// result sits in an output register: a stalled response holds its beat,
// and the next request can be taken meanwhile, but finishing it waits until
// the held beat leaves.
`timescale 1ns / 1ps

module indexed_priority_queue #(
   parameter int NUM_IDS  = 128,
   parameter int KEY_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ipq_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output ipq_pkg::rsp_type rsp_data,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   import ipq_pkg::*;

   localparam int IW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
   localparam int SW = $clog2(NUM_IDS + 1);
   localparam int HW = IW + KEY_BITS;

   state_type state_ff, state_in;

   logic [SW-1:0]       cnt_ff, cnt_in;
   logic [SW-1:0]       pos_ff, pos_in;
   logic [SW-1:0]       cpos_ff, cpos_in;
   logic [IW-1:0]       cur_id_ff, cur_id_in;
   logic [KEY_BITS-1:0] cur_key_ff, cur_key_in;
   logic [IW-1:0]       ch_id_ff, ch_id_in;
   logic [KEY_BITS-1:0] ch_key_ff, ch_key_in;
   logic [IW-1:0]       id_ff, id_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                in_range_ff, in_range_in;
   logic [IW-1:0]       clr_ptr_ff, clr_ptr_in;
   logic                clr_rsp_ff, clr_rsp_in;
   logic                status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                max_mode_ff;

   logic                heap_we, heap_re;
   logic [SW-1:0]       heap_wa, heap_ra;
   logic [HW-1:0]       heap_wd, heap_rd;
   logic                map_we, map_re;
   logic [IW-1:0]       map_wa, map_ra;
   logic [SW-1:0]       map_wd, map_rd;

   logic [IW-1:0]       rd_id;
   logic [KEY_BITS-1:0] rd_key;
   logic [SW:0]         child;

   assign rd_id  = heap_rd[HW-1:KEY_BITS];
   assign rd_key = heap_rd[KEY_BITS-1:0];
   assign child  = {pos_ff, 1'b0};

   function automatic logic better(input logic [KEY_BITS-1:0] a,
                                   input logic [KEY_BITS-1:0] b,
                                   input logic                mx);
      return mx ? (a > b) : (a < b);
   endfunction

   // heap slots 1..NUM_IDS, slot 0 unused
   ipq_ram #(.WIDTH(HW), .DEPTH(NUM_IDS + 1), .AW(SW)) u_heap (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_wa),
      .wr_data (heap_wd),
      .rd_en   (heap_re),
      .rd_addr (heap_ra),
      .rd_data (heap_rd)
   );

   // slot of each id, zero when absent
   ipq_ram #(.WIDTH(SW), .DEPTH(NUM_IDS), .AW(IW)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wa),
      .wr_data (map_wd),
      .rd_en   (map_re),
      .rd_addr (map_ra),
      .rd_data (map_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         cnt_ff       <= '0;
         clr_ptr_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_mode_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_ptr_ff   <= clr_ptr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      cpos_ff     <= cpos_in;
      cur_id_ff   <= cur_id_in;
      cur_key_ff  <= cur_key_in;
      ch_id_ff    <= ch_id_in;
      ch_key_ff   <= ch_key_in;
      id_ff       <= id_in;
      key_ff      <= key_in;
      in_range_ff <= in_range_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      cpos_in      = cpos_ff;
      cur_id_in    = cur_id_ff;
      cur_key_in   = cur_key_ff;
      ch_id_in     = ch_id_ff;
      ch_key_in    = ch_key_ff;
      id_in        = id_ff;
      key_in       = key_ff;
      in_range_in  = in_range_ff;
      clr_ptr_in   = clr_ptr_ff;
      clr_rsp_in   = clr_rsp_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      heap_we      = 1'b0;
      heap_wa      = '0;
      heap_wd      = '0;
      heap_re      = 1'b0;
      heap_ra      = '0;
      map_we       = 1'b0;
      map_wa       = '0;
      map_wd       = '0;
      map_re       = 1'b0;
      map_ra       = '0;
      req_stall    = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               id_in       = IW'(req_data.index);
               key_in      = KEY_BITS'(req_data.key_value);
               in_range_in = (32'(req_data.index) < NUM_IDS);
               status_in   = ST_OK;
               case (req_data.op)
                  OP_PUSH:  state_in = S_P_MAP;
                  OP_POP:   state_in = S_O_START;
                  OP_CLEAR: begin
                     cnt_in     = '0;
                     clr_ptr_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLR;
                  end
                  default:  state_in = S_TOP;
               endcase
            end
         end
         S_P_MAP: begin
            if (!in_range_ff) begin
               state_in = S_TOP;
            end else begin
               map_re   = 1'b1;
               map_ra   = id_ff;
               state_in = S_P_MAPW;
            end
         end
         S_P_MAPW: begin
            if (map_rd == '0) begin
               if (cnt_ff == SW'(NUM_IDS)) begin
                  state_in = S_TOP;
               end else begin
                  cnt_in     = cnt_ff + 1'b1;
                  pos_in     = cnt_ff + 1'b1;
                  cur_id_in  = id_ff;
                  cur_key_in = key_ff;
                  state_in   = S_UP;
               end
            end else begin
               pos_in   = map_rd;
               heap_re  = 1'b1;
               heap_ra  = map_rd;
               state_in = S_P_CMP;
            end
         end
         S_P_CMP: begin
            if (better(key_ff, rd_key, max_mode_ff)) begin
               cur_id_in  = id_ff;
               cur_key_in = key_ff;
               state_in   = S_UP;
            end else begin
               state_in = S_TOP;
            end
         end
         // moving entry stays in cur_*; its slot is written once it settles
         S_UP: begin
            if (pos_ff == SW'(1)) begin
               heap_we  = 1'b1;
               heap_wa  = pos_ff;
               heap_wd  = {cur_id_ff, cur_key_ff};
               map_we   = 1'b1;
               map_wa   = cur_id_ff;
               map_wd   = pos_ff;
               state_in = S_TOP;
            end else begin
               heap_re  = 1'b1;
               heap_ra  = pos_ff >> 1;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            heap_we = 1'b1;
            heap_wa = pos_ff;
            map_we  = 1'b1;
            map_wd  = pos_ff;
            if (better(cur_key_ff, rd_key, max_mode_ff)) begin
               heap_wd  = heap_rd;
               map_wa   = rd_id;
               pos_in   = pos_ff >> 1;
               state_in = S_UP;
            end else begin
               heap_wd  = {cur_id_ff, cur_key_ff};
               map_wa   = cur_id_ff;
               state_in = S_TOP;
            end
         end
         S_O_START: begin
            if (cnt_ff == '0) begin
               status_in = ST_EMPTY;
               state_in  = S_TOP;
            end else begin
               heap_re  = 1'b1;
               heap_ra  = SW'(1);
               state_in = S_O_R1;
            end
         end
         S_O_R1: begin
            map_we   = 1'b1;
            map_wa   = rd_id;
            map_wd   = '0;
            heap_re  = 1'b1;
            heap_ra  = cnt_ff;
            state_in = S_O_RL;
         end
         S_O_RL: begin
            cur_id_in  = rd_id;
            cur_key_in = rd_key;
            cnt_in     = cnt_ff - 1'b1;
            pos_in     = SW'(1);
            state_in   = (cnt_ff == SW'(1)) ? S_TOP : S_DN;
         end
         S_DN: begin
            if (child > {1'b0, cnt_ff}) begin
               heap_we  = 1'b1;
               heap_wa  = pos_ff;
               heap_wd  = {cur_id_ff, cur_key_ff};
               map_we   = 1'b1;
               map_wa   = cur_id_ff;
               map_wd   = pos_ff;
               state_in = S_TOP;
            end else begin
               heap_re  = 1'b1;
               heap_ra  = SW'(child);
               cpos_in  = SW'(child);
               state_in = S_DN_L;
            end
         end
         S_DN_L: begin
            ch_id_in  = rd_id;
            ch_key_in = rd_key;
            if (cpos_ff < cnt_ff) begin
               heap_re  = 1'b1;
               heap_ra  = cpos_ff + 1'b1;
               state_in = S_DN_R;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_R: begin
            // right child only when strictly better
            if (better(rd_key, ch_key_ff, max_mode_ff)) begin
               ch_id_in  = rd_id;
               ch_key_in = rd_key;
               cpos_in   = cpos_ff + 1'b1;
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            heap_we = 1'b1;
            heap_wa = pos_ff;
            map_we  = 1'b1;
            map_wd  = pos_ff;
            if (better(ch_key_ff, cur_key_ff, max_mode_ff)) begin
               heap_wd  = {ch_id_ff, ch_key_ff};
               map_wa   = ch_id_ff;
               pos_in   = cpos_ff;
               state_in = S_DN;
            end else begin
               heap_wd  = {cur_id_ff, cur_key_ff};
               map_wa   = cur_id_ff;
               state_in = S_TOP;
            end
         end
         S_CLR: begin
            map_we = 1'b1;
            map_wa = clr_ptr_ff;
            map_wd = '0;
            if (clr_ptr_ff == IW'(NUM_IDS - 1)) begin
               state_in = clr_rsp_ff ? S_TOP : S_IDLE;
            end else begin
               clr_ptr_in = clr_ptr_ff + 1'b1;
            end
         end
         S_TOP: begin
            heap_re  = 1'b1;
            heap_ra  = SW'(1);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.count     = 8'(cnt_ff);
               rsp_data_in.is_empty  = (cnt_ff == '0);
               rsp_data_in.status    = status_ff;
               if (cnt_ff == '0) begin
                  rsp_data_in.top_index = '0;
                  rsp_data_in.top_key   = '0;
               end else begin
                  rsp_data_in.top_index = 7'(rd_id);
                  rsp_data_in.top_key   = 32'(rd_key);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/ipq_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the heap slots and the position map. No package dependency.
`timescale 1ns / 1ps

module ipq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[verif/tb_indexed_priority_queue.sv]
// Testbench for indexed_priority_queue: random and directed push, pop, clear and
// unused-op beats checked against an in-bench heap predictor. Depends on ipq_pkg and the RTL.
`timescale 1ns / 1ps

module tb_indexed_priority_queue;
   import ipq_pkg::*;

   localparam int N_IDS = 128;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;
   logic req_taken = 1'b0;

   indexed_priority_queue dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [6:0]  hp_id [1:N_IDS];
   logic [31:0] hp_key [1:N_IDS];
   logic [7:0]  slot_map [0:N_IDS-1];
   int          n_held;
   logic        max_first;

   req_type pending_beats[$];
   rsp_type expected_rsp[$];
   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   int hold_cycles = 0;
   int mismatches = 0;
   int cycles = 0;

   function automatic bit outranks(logic [31:0] a, logic [31:0] b);
      return max_first ? (a > b) : (a < b);
   endfunction

   function automatic void swap_entries(int a, int b);
      logic [6:0]  ti;
      logic [31:0] tk;
      ti = hp_id[a]; tk = hp_key[a];
      hp_id[a] = hp_id[b]; hp_key[a] = hp_key[b];
      hp_id[b] = ti; hp_key[b] = tk;
      slot_map[hp_id[a]] = a[7:0];
      slot_map[hp_id[b]] = b[7:0];
   endfunction

   function automatic void bubble_up(int p);
      while (p > 1 && outranks(hp_key[p], hp_key[p/2])) begin
         swap_entries(p, p/2);
         p = p / 2;
      end
   endfunction

   function automatic void bubble_down(int p);
      int c;
      forever begin
         c = 2 * p;
         if (c > n_held) break;
         if (c < n_held && outranks(hp_key[c+1], hp_key[c])) c++;
         if (!outranks(hp_key[c], hp_key[p])) break;
         swap_entries(c, p);
         p = c;
      end
   endfunction

   function automatic rsp_type heap_apply(req_type r);
      rsp_type o;
      int s;
      o = '0;
      o.status = ST_OK;
      case (r.op)
         OP_PUSH: begin
            s = slot_map[r.index];
            if (s == 0) begin
               if (n_held < N_IDS) begin
                  n_held++;
                  hp_id[n_held] = r.index;
                  hp_key[n_held] = r.key_value;
                  slot_map[r.index] = n_held[7:0];
                  bubble_up(n_held);
               end
            end else if (outranks(r.key_value, hp_key[s])) begin
               hp_key[s] = r.key_value;
               bubble_up(s);
            end
         end
         OP_POP: begin
            if (n_held == 0) o.status = ST_EMPTY;
            else begin
               slot_map[hp_id[1]] = '0;
               hp_id[1] = hp_id[n_held];
               hp_key[1] = hp_key[n_held];
               n_held--;
               if (n_held > 0) begin
                  slot_map[hp_id[1]] = 8'd1;
                  bubble_down(1);
               end
            end
         end
         OP_CLEAR: begin
            n_held = 0;
            foreach (slot_map[i]) slot_map[i] = '0;
         end
         default: ;
      endcase
      if (n_held > 0) begin
         o.top_index = hp_id[1];
         o.top_key = hp_key[1];
      end
      o.count = n_held[7:0];
      o.is_empty = (n_held == 0);
      return o;
   endfunction

   // sender: a new beat only once the held one was taken at the last rising edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               req_data <= pending_beats.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold counted down here
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_gap_pct);
         end
      end
   end

   // monitor: predict on request beat, check on response beat
   always @(posedge clock) begin
      rsp_type got, want;
      cycles <= cycles + 1;
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) expected_rsp.push_back(heap_apply(req_data));
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response beat %h", got);
            end else begin
               want = expected_rsp.pop_front();
               if (got.top_index !== want.top_index || got.top_key !== want.top_key ||
                   got.count !== want.count || got.is_empty !== want.is_empty ||
                   got.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp id %0d key %h cnt %0d emp %b st %b,",
                               " got id %0d key %h cnt %0d emp %b st %b"},
                        want.top_index, want.top_key, want.count, want.is_empty,
                        want.status, got.top_index, got.top_key, got.count,
                        got.is_empty, got.status);
               end
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_indexed_priority_queue: done, errors");
         $finish;
      end
   end

   function automatic req_type mk(logic [1:0] op, logic [6:0] id, logic [31:0] key);
      req_type r;
      r.op = op; r.index = id; r.key_value = key;
      return r;
   endfunction

   function automatic logic [31:0] rand_key();
      case ($urandom_range(3))
         0: return $urandom_range(15);
         1: return 32'hFFFF_FFFF - $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   task automatic drain();
      wait (pending_beats.size() == 0 && !req_valid);
      wait (expected_rsp.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_mode(logic m);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      max_first = m;
   endtask

   // mostly pushes over ids 0..id_span so that improvements and deep heaps occur
   task automatic queue_random(int cnt, int id_span);
      int k;
      repeat (cnt) begin
         k = $urandom_range(99);
         if (k < 60)
            pending_beats.push_back(mk(OP_PUSH, 7'($urandom_range(id_span)), rand_key()));
         else if (k < 92)
            pending_beats.push_back(mk(OP_POP, 7'($urandom), $urandom));
         else if (k < 96)
            pending_beats.push_back(mk(OP_CLEAR, 7'($urandom), $urandom));
         else
            pending_beats.push_back(mk(OP_UNUSED, 7'($urandom), $urandom));
      end
   endtask

   initial begin
      n_held = 0;
      max_first = 1'b0;
      foreach (slot_map[i]) slot_map[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: min mode
      set_mode(1'b0);
      pending_beats.push_back(mk(OP_POP, 7'd5, 32'd1));
      pending_beats.push_back(mk(OP_PUSH, 7'd0, 32'hFFFF_FFFF));
      pending_beats.push_back(mk(OP_PUSH, 7'd127, 32'd0));
      pending_beats.push_back(mk(OP_PUSH, 7'd64, 32'd100));
      pending_beats.push_back(mk(OP_PUSH, 7'd64, 32'd200));
      pending_beats.push_back(mk(OP_PUSH, 7'd64, 32'd100));
      pending_beats.push_back(mk(OP_PUSH, 7'd0, 32'd50));
      pending_beats.push_back(mk(OP_UNUSED, 7'h55, 32'h5555_5555));
      pending_beats.push_back(mk(OP_PUSH, 7'd1, 32'd0));
      pending_beats.push_back(mk(OP_POP, 7'd0, 32'd0));
      pending_beats.push_back(mk(OP_POP, 7'd0, 32'd0));
      pending_beats.push_back(mk(OP_CLEAR, 7'h2A, 32'hAAAA_AAAA));
      pending_beats.push_back(mk(OP_POP, 7'd0, 32'd0));
      pending_beats.push_back(mk(OP_PUSH, 7'd9, 32'h8000_0000));
      pending_beats.push_back(mk(OP_PUSH, 7'd10, 32'h7FFF_FFFF));
      drain();
      // mode change with entries held: no reorder
      set_mode(1'b1);
      pending_beats.push_back(mk(OP_PUSH, 7'd11, 32'hFFFF_FFFF));
      pending_beats.push_back(mk(OP_PUSH, 7'd9, 32'hFFFF_FFFF));
      pending_beats.push_back(mk(OP_POP, 7'd0, 32'd0));
      pending_beats.push_back(mk(OP_POP, 7'd0, 32'd0));
      pending_beats.push_back(mk(OP_POP, 7'd0, 32'd0));
      drain();

      // fill all 128 ids, then random beats over the full id range
      for (int i = 0; i < N_IDS; i++)
         pending_beats.push_back(mk(OP_PUSH, i[6:0], rand_key()));
      drain();
      set_mode(1'b0);
      send_gap_pct = 32; recv_gap_pct = 75;
      queue_random(85, 127);
      drain();

      set_mode(1'b1);
      send_gap_pct = 75; recv_gap_pct = 32;
      queue_random(85, 31);
      // receiver holds off long while the sender keeps offering
      hold_cycles = 600;
      drain();

      set_mode(1'b0);
      send_gap_pct = 0; recv_gap_pct = 0;
      queue_random(80, 15);
      drain();

      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("tb_indexed_priority_queue: done, clean");
      end else begin
         $display("tb_indexed_priority_queue: done, errors");
      end
      $finish;
   end
endmodule
